// ===== hw/rtl/ssce_pkg.sv =====
// Package with the shared constants, types and state codes of the subset-sum enumerator.
package ssce_pkg;

    localparam int MAX_ITEMS_DEF   = 12;
    localparam int VALUE_LIMIT_DEF = 1023;

    localparam int VAL_W    = 10;
    localparam int MULT_W   = 4;
    localparam int SUM_W    = 14;
    localparam int PROD_W   = VAL_W + MULT_W;
    localparam int X_W      = SUM_W + 1;
    localparam int DATA_W   = 16;

    localparam logic              KIND_LOAD = 1'b0;
    localparam logic              KIND_NEXT = 1'b1;
    localparam logic [MULT_W-1:0] MULT_MAX  = 4'd15;

    typedef enum logic [1:0] {
        STAT_TERM    = 2'd0,
        STAT_NO_MORE = 2'd1,
        STAT_NONE    = 2'd2
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [VAL_W-1:0]     value;
        logic [MULT_W-1:0]    count;
        logic                 last;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_CMP,
        S_TOP,
        S_EVAL,
        S_DECIDE,
        S_ADV,
        S_POP_STK,
        S_POP_SET,
        S_END,
        S_EM_STK,
        S_EM_SET,
        S_EM_OUT
    } t_state;

endpackage

// ===== hw/rtl/ssce_ram.sv =====
// Synchronous memory with one write port and one registered read port.
module ssce_ram #(
    parameter  int DEPTH = 12,
    parameter  int WIDTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ssce_outreg.sv =====
// Output register holding one result item until the downstream side takes it.
module ssce_outreg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  ssce_pkg::t_result        i_result,
    output logic                     o_free,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [ssce_pkg::DATA_W-1:0] o_m_tdata,
    output logic [1:0]               o_m_tuser,
    output logic                     o_m_tlast
);

    logic              r_valid;
    logic              n_valid;
    ssce_pkg::t_result r_res;

    assign o_free  = !r_valid || i_m_tready;
    assign n_valid = i_push || (r_valid && !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{(ssce_pkg::DATA_W - ssce_pkg::PROD_W){1'b0}}, r_res.count, r_res.value};
    assign o_m_tuser  = r_res.status;
    assign o_m_tlast  = r_res.last;

endmodule

// ===== hw/rtl/subset_sum_combination_enumerator_unit.sv =====
// Top level of the subset-sum enumerator: search sequencer, set and stack memories.
//
//  channel  | direction | handshake              | payload
//  s        | in        | i_s_tvalid/o_s_tready  | tdata value,first; tuser kind
//  m        | out       | o_m_tvalid/i_m_tready  | tdata term_value,term_count; tuser status; tlast
//  cfg      | in        | i_cfg_valid/o_cfg_ready| target_sum
//
// A load compares its value with each stored distinct value in turn, in S_LD_RD and S_LD_CMP,
// and appends it if it is new; a load of zero is accepted without a search.
// A request runs for a data-dependent time made of search steps (S_TOP, S_EVAL, S_DECIDE,
// S_ADV), popped levels (S_POP_STK, S_POP_SET) and emitted terms (S_EM_STK to S_EM_OUT).
// Reset is synchronous and clears the control state; the memories need no clearing.
// A stalled output holds the sequencer only while a result is waiting to be placed.
module subset_sum_combination_enumerator_unit #(
    parameter int MAX_ITEMS   = ssce_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_LIMIT = ssce_pkg::VALUE_LIMIT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [ssce_pkg::DATA_W-1:0] i_s_tdata,   // value[9:0], first[10], zero
    input  logic                        i_s_tuser,   // kind[0]
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [ssce_pkg::DATA_W-1:0] o_m_tdata,   // term_value[9:0], term_count[13:10], zero
    output logic [1:0]                  o_m_tuser,   // status[1:0]
    output logic                        o_m_tlast,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ssce_pkg::SUM_W-1:0]  i_cfg_data
);

    localparam int CW    = $clog2(MAX_ITEMS + 1);
    localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int VW    = ssce_pkg::VAL_W;
    localparam int MW    = ssce_pkg::MULT_W;
    localparam int SW    = ssce_pkg::SUM_W;
    localparam int XW    = ssce_pkg::X_W;
    localparam int PW    = ssce_pkg::PROD_W;
    localparam int LIM_W = 17;
    localparam int SET_W = VW + MW;
    localparam int STK_W = CW + MW;

    ssce_pkg::t_state  r_state, n_state;
    logic [SW-1:0]     r_target;
    logic [CW-1:0]     r_dcount, n_dcount;
    logic [CW-1:0]     r_depth, n_depth;
    logic [SW-1:0]     r_psum, n_psum;
    logic              r_found, n_found;
    logic              r_started, n_started;
    logic [CW-1:0]     r_tidx, n_tidx;
    logic [MW-1:0]     r_tcnt, n_tcnt;
    logic [VW-1:0]     r_tval, n_tval;
    logic [CW-1:0]     r_nidx, n_nidx;
    logic [VW-1:0]     r_val, n_val;
    logic [MW-1:0]     r_ecnt, n_ecnt;
    logic [XW-1:0]     r_x, n_x;

    logic              set_we, set_re, stk_we, stk_re;
    logic [AW-1:0]     set_waddr, set_raddr, stk_waddr, stk_raddr;
    logic [SET_W-1:0]  set_wdata, set_rdata;
    logic [STK_W-1:0]  stk_wdata, stk_rdata;
    logic [VW-1:0]     set_rval;
    logic [MW-1:0]     set_rmult;
    logic [CW-1:0]     stk_ridx;
    logic [MW-1:0]     stk_rcnt;

    logic              in_acc;
    logic              in_kind, in_first;
    logic [VW-1:0]     in_val;
    logic              in_bad;
    logic              out_free, out_push;
    ssce_pkg::t_result out_res;
    logic [PW-1:0]     w_prod, w_pop_prod;
    logic [CW-1:0]     w_tidx_inc;
    logic [CW-1:0]     w_top_addr, w_below_addr;
    logic              w_hit, w_push, w_has_next, w_last_term;

    assign o_s_tready  = (r_state == ssce_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign in_kind     = i_s_tuser;
    assign in_val      = i_s_tdata[VW-1:0];
    assign in_first    = i_s_tdata[VW];
    assign in_bad      = (in_val == '0) ||
                         (LIM_W'(in_val) > LIM_W'(VALUE_LIMIT));

    assign {set_rval, set_rmult} = set_rdata;
    assign {stk_ridx, stk_rcnt}  = stk_rdata;

    assign w_prod       = r_tval * r_tcnt;
    assign w_pop_prod   = set_rval * r_tcnt;
    assign w_tidx_inc   = r_tidx + CW'(1);
    assign w_top_addr   = r_depth - CW'(1);
    assign w_below_addr = r_depth - CW'(2);
    assign w_has_next   = (w_tidx_inc < r_dcount);
    assign w_hit        = (r_x == XW'(r_target));
    assign w_push       = (r_x < XW'(r_target)) && w_has_next && (r_depth < CW'(MAX_ITEMS));
    assign w_last_term  = (r_nidx == (r_depth - CW'(1)));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssce_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (in_kind == ssce_pkg::KIND_LOAD) begin
                        n_state = in_bad ? ssce_pkg::S_IDLE : ssce_pkg::S_LD_RD;
                    end else if (!r_started) begin
                        n_state = (r_dcount == '0) ? ssce_pkg::S_END : ssce_pkg::S_TOP;
                    end else begin
                        n_state = (r_depth == '0) ? ssce_pkg::S_END : ssce_pkg::S_ADV;
                    end
                end
            end
            ssce_pkg::S_LD_RD: begin
                n_state = (r_nidx < r_dcount) ? ssce_pkg::S_LD_CMP : ssce_pkg::S_IDLE;
            end
            ssce_pkg::S_LD_CMP: begin
                n_state = (set_rval == r_val) ? ssce_pkg::S_IDLE : ssce_pkg::S_LD_RD;
            end
            ssce_pkg::S_TOP:  n_state = ssce_pkg::S_EVAL;
            ssce_pkg::S_EVAL: n_state = ssce_pkg::S_DECIDE;
            ssce_pkg::S_DECIDE: begin
                if (w_hit) begin
                    n_state = ssce_pkg::S_EM_STK;
                end else if (w_push) begin
                    n_state = ssce_pkg::S_TOP;
                end else begin
                    n_state = ssce_pkg::S_ADV;
                end
            end
            ssce_pkg::S_ADV: begin
                if (r_tcnt > MW'(1)) begin
                    n_state = ssce_pkg::S_EVAL;
                end else if (w_has_next) begin
                    n_state = ssce_pkg::S_TOP;
                end else if (r_depth == CW'(1)) begin
                    n_state = ssce_pkg::S_END;
                end else begin
                    n_state = ssce_pkg::S_POP_STK;
                end
            end
            ssce_pkg::S_POP_STK: n_state = ssce_pkg::S_POP_SET;
            ssce_pkg::S_POP_SET: n_state = ssce_pkg::S_ADV;
            ssce_pkg::S_END: begin
                if (out_free) begin
                    n_state = ssce_pkg::S_IDLE;
                end
            end
            ssce_pkg::S_EM_STK: n_state = ssce_pkg::S_EM_SET;
            ssce_pkg::S_EM_SET: n_state = ssce_pkg::S_EM_OUT;
            ssce_pkg::S_EM_OUT: begin
                if (out_free) begin
                    n_state = w_last_term ? ssce_pkg::S_IDLE : ssce_pkg::S_EM_STK;
                end
            end
            default: n_state = ssce_pkg::S_IDLE;
        endcase
    end

    // Datapath, memory accesses and result placement.
    always_comb begin
        n_dcount  = r_dcount;
        n_depth   = r_depth;
        n_psum    = r_psum;
        n_found   = r_found;
        n_started = r_started;
        n_tidx    = r_tidx;
        n_tcnt    = r_tcnt;
        n_tval    = r_tval;
        n_nidx    = r_nidx;
        n_val     = r_val;
        n_ecnt    = r_ecnt;
        n_x       = r_x;
        set_we    = 1'b0;
        set_waddr = r_dcount[AW-1:0];
        set_wdata = {r_val, MW'(1)};
        set_re    = 1'b0;
        set_raddr = r_nidx[AW-1:0];
        stk_we    = 1'b0;
        stk_waddr = w_top_addr[AW-1:0];
        stk_wdata = {r_tidx, r_tcnt};
        stk_re    = 1'b0;
        stk_raddr = r_nidx[AW-1:0];
        out_push  = 1'b0;
        out_res   = '{status: ssce_pkg::STAT_TERM, value: set_rval, count: r_ecnt,
                      last: w_last_term};
        unique case (r_state)
            ssce_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (in_kind == ssce_pkg::KIND_LOAD) begin
                        if (in_first) begin
                            n_dcount = '0;
                        end
                        n_started = 1'b0;
                        n_found   = 1'b0;
                        n_depth   = '0;
                        n_psum    = '0;
                        n_val     = in_val;
                        n_nidx    = '0;
                    end else if (!r_started) begin
                        n_started = 1'b1;
                        n_psum    = '0;
                        n_nidx    = '0;
                        if (r_dcount == '0) begin
                            n_depth = '0;
                        end else begin
                            n_depth   = CW'(1);
                            set_re    = 1'b1;
                            set_raddr = '0;
                        end
                    end
                end
            end
            ssce_pkg::S_LD_RD: begin
                if (r_nidx < r_dcount) begin
                    set_re = 1'b1;
                end else if (r_dcount < CW'(MAX_ITEMS)) begin
                    set_we   = 1'b1;
                    n_dcount = r_dcount + CW'(1);
                end
            end
            ssce_pkg::S_LD_CMP: begin
                if (set_rval == r_val) begin
                    set_we    = (set_rmult != ssce_pkg::MULT_MAX);
                    set_waddr = r_nidx[AW-1:0];
                    set_wdata = {set_rval, set_rmult + MW'(1)};
                end else begin
                    n_nidx = r_nidx + CW'(1);
                end
            end
            ssce_pkg::S_TOP: begin
                n_tidx    = r_nidx;
                n_tcnt    = set_rmult;
                n_tval    = set_rval;
                stk_we    = 1'b1;
                stk_wdata = {r_nidx, set_rmult};
            end
            ssce_pkg::S_EVAL: begin
                n_x = XW'(r_psum) + XW'(w_prod);
            end
            ssce_pkg::S_DECIDE: begin
                if (w_hit) begin
                    n_found = 1'b1;
                    n_nidx  = '0;
                end else if (w_push) begin
                    n_psum    = r_x[SW-1:0];
                    n_depth   = r_depth + CW'(1);
                    n_nidx    = w_tidx_inc;
                    set_re    = 1'b1;
                    set_raddr = w_tidx_inc[AW-1:0];
                end
            end
            ssce_pkg::S_ADV: begin
                if (r_tcnt > MW'(1)) begin
                    n_tcnt    = r_tcnt - MW'(1);
                    stk_we    = 1'b1;
                    stk_wdata = {r_tidx, r_tcnt - MW'(1)};
                end else if (w_has_next) begin
                    n_nidx    = w_tidx_inc;
                    set_re    = 1'b1;
                    set_raddr = w_tidx_inc[AW-1:0];
                end else begin
                    n_depth = r_depth - CW'(1);
                    if (r_depth != CW'(1)) begin
                        stk_re    = 1'b1;
                        stk_raddr = w_below_addr[AW-1:0];
                    end
                end
            end
            ssce_pkg::S_POP_STK: begin
                n_tidx    = stk_ridx;
                n_tcnt    = stk_rcnt;
                set_re    = 1'b1;
                set_raddr = stk_ridx[AW-1:0];
            end
            ssce_pkg::S_POP_SET: begin
                n_tval = set_rval;
                n_psum = r_psum - SW'(w_pop_prod);
            end
            ssce_pkg::S_END: begin
                out_push = out_free;
                out_res  = '{status: (r_found ? ssce_pkg::STAT_NO_MORE : ssce_pkg::STAT_NONE),
                             value: '0, count: '0, last: 1'b1};
            end
            ssce_pkg::S_EM_STK: begin
                stk_re = 1'b1;
            end
            ssce_pkg::S_EM_SET: begin
                n_ecnt    = stk_rcnt;
                set_re    = 1'b1;
                set_raddr = stk_ridx[AW-1:0];
            end
            ssce_pkg::S_EM_OUT: begin
                out_push = out_free;
                if (out_free) begin
                    n_nidx = r_nidx + CW'(1);
                end
            end
            default: begin
                out_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ssce_pkg::S_IDLE;
            r_target  <= '0;
            r_dcount  <= '0;
            r_depth   <= '0;
            r_psum    <= '0;
            r_found   <= 1'b0;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_dcount  <= n_dcount;
            r_depth   <= n_depth;
            r_psum    <= n_psum;
            r_found   <= n_found;
            r_started <= n_started;
            if (i_cfg_valid && o_cfg_ready) begin
                r_target <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tidx <= n_tidx;
        r_tcnt <= n_tcnt;
        r_tval <= n_tval;
        r_nidx <= n_nidx;
        r_val  <= n_val;
        r_ecnt <= n_ecnt;
        r_x    <= n_x;
    end

    ssce_ram #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (SET_W)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (set_we),
        .i_waddr (set_waddr),
        .i_wdata (set_wdata),
        .i_re    (set_re),
        .i_raddr (set_raddr),
        .o_rdata (set_rdata)
    );

    ssce_ram #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (STK_W)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    ssce_outreg u_outreg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (out_push),
        .i_result   (out_res),
        .o_free     (out_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

`ifndef ASSERT_OFF
    a_dcount_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dcount <= CW'(MAX_ITEMS))
        else $error("distinct count exceeds the set size");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= r_dcount)
        else $error("search depth exceeds the distinct count");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_push && out_res.last) |=> (r_state == ssce_pkg::S_IDLE))
        else $error("sequencer busy after the final result item");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> out_free)
        else $error("result placed while the output register is occupied");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the subset-sum combination enumerator unit.
module tb_top;

    localparam int IDLE_LIMIT = 400000;

    typedef struct {
        bit       kind;
        bit [9:0] value;
        bit       first;
    } t_item;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_s_tvalid  = 1'b0;
    logic                          o_s_tready;
    logic [ssce_pkg::DATA_W-1:0]   i_s_tdata   = '0;
    logic                          i_s_tuser   = 1'b0;
    logic                          o_m_tvalid;
    logic                          i_m_tready  = 1'b0;
    logic [ssce_pkg::DATA_W-1:0]   o_m_tdata;
    logic [1:0]                    o_m_tuser;
    logic                          o_m_tlast;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [ssce_pkg::SUM_W-1:0]    i_cfg_data  = '0;

    t_item             item_q[$];
    ssce_pkg::t_result term_q[$];
    t_item             cur_item;
    int                mismatches = 0;
    int                send_idle_pct = 24;
    int                recv_idle_pct = 77;
    bit                hold_req = 1'b0;
    int                hold_left = 0;
    int                quiet_cycles = 0;

    // Shadow of the enumerator state.
    bit [9:0] set_val[ssce_pkg::MAX_ITEMS_DEF];
    bit [3:0] set_mult[ssce_pkg::MAX_ITEMS_DEF];
    int       set_cnt = 0;
    int       lvl_idx[ssce_pkg::MAX_ITEMS_DEF];
    int       lvl_cnt[ssce_pkg::MAX_ITEMS_DEF];
    int       depth = 0;
    int       psum = 0;
    bit       found = 1'b0;
    bit       started = 1'b0;
    int       target = 0;

    subset_sum_combination_enumerator_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bit step_top();
        int t;
        while (depth > 0) begin
            t = depth - 1;
            if (lvl_cnt[t] > 1) begin
                lvl_cnt[t]--;
                return 1'b1;
            end
            lvl_idx[t]++;
            if (lvl_idx[t] < set_cnt) begin
                lvl_cnt[t] = set_mult[lvl_idx[t]];
                return 1'b1;
            end
            depth--;
            if (depth == 0)
                return 1'b0;
            t = depth - 1;
            psum -= set_val[lvl_idx[t]] * lvl_cnt[t];
        end
        return 1'b0;
    endfunction

    function automatic void push_exhausted();
        ssce_pkg::t_result r;
        r.status = found ? ssce_pkg::STAT_NO_MORE : ssce_pkg::STAT_NONE;
        r.value  = '0;
        r.count  = '0;
        r.last   = 1'b1;
        term_q.push_back(r);
    endfunction

    function automatic void predict_terms(t_item it);
        int                t;
        int                x;
        ssce_pkg::t_result r;
        if (it.kind == ssce_pkg::KIND_LOAD) begin
            if (it.first)
                set_cnt = 0;
            started = 1'b0;
            found   = 1'b0;
            depth   = 0;
            psum    = 0;
            if (it.value == 0)
                return;
            for (int i = 0; i < set_cnt; i++) begin
                if (set_val[i] == it.value) begin
                    if (set_mult[i] != ssce_pkg::MULT_MAX)
                        set_mult[i]++;
                    return;
                end
            end
            if (set_cnt < ssce_pkg::MAX_ITEMS_DEF) begin
                set_val[set_cnt]  = it.value;
                set_mult[set_cnt] = 4'd1;
                set_cnt++;
            end
            return;
        end
        if (!started) begin
            started = 1'b1;
            psum    = 0;
            if (set_cnt == 0) begin
                depth = 0;
                push_exhausted();
                return;
            end
            depth      = 1;
            lvl_idx[0] = 0;
            lvl_cnt[0] = set_mult[0];
        end else if (depth == 0 || !step_top()) begin
            push_exhausted();
            return;
        end
        forever begin
            t = depth - 1;
            x = psum + set_val[lvl_idx[t]] * lvl_cnt[t];
            if (x == target) begin
                found = 1'b1;
                for (int k = 0; k <= t; k++) begin
                    r.status = ssce_pkg::STAT_TERM;
                    r.value  = set_val[lvl_idx[k]];
                    r.count  = lvl_cnt[k][3:0];
                    r.last   = (k == t);
                    term_q.push_back(r);
                end
                return;
            end
            if (x < target && lvl_idx[t] + 1 < set_cnt
                && depth < ssce_pkg::MAX_ITEMS_DEF) begin
                psum           = x;
                lvl_idx[t + 1] = lvl_idx[t] + 1;
                lvl_cnt[t + 1] = set_mult[lvl_idx[t + 1]];
                depth++;
                continue;
            end
            if (!step_top()) begin
                push_exhausted();
                return;
            end
        end
    endfunction

    // Source side: one item offered at a time from the pending queue.
    always @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready)
            predict_terms(cur_item);
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                cur_item   <= item_q[0];
                i_s_tdata  <= {5'b0, item_q[0].first, item_q[0].value};
                i_s_tuser  <= item_q[0].kind;
                i_s_tvalid <= 1'b1;
                void'(item_q.pop_front());
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: random back-pressure and one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_req && hold_left == 0 && i_m_tready) begin
            hold_left  <= 600;
            i_m_tready <= 1'b0;
        end else if (hold_left > 1) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            if (hold_left == 1)
                hold_left <= 0;
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        ssce_pkg::t_result e;
        if (o_m_tvalid && i_m_tready) begin
            if (term_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: status %0d value %0d count %0d last %0d",
                             o_m_tuser, o_m_tdata[9:0], o_m_tdata[13:10], o_m_tlast);
            end else begin
                e = term_q.pop_front();
                if (o_m_tuser != e.status || o_m_tdata[9:0] != e.value
                    || o_m_tdata[13:10] != e.count || o_m_tlast != e.last
                    || o_m_tdata[15:14] != 2'b0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 e.status, e.value, e.count, e.last, o_m_tuser,
                                 o_m_tdata[9:0], o_m_tdata[13:10], o_m_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic add_item(bit kind, bit [9:0] value, bit first);
        t_item it;
        it.kind  = kind;
        it.value = value;
        it.first = first;
        item_q.push_back(it);
    endtask

    task automatic drain();
        while (item_q.size() != 0 || i_s_tvalid || term_q.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_target(bit [ssce_pkg::SUM_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        target = v;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One run: a load that clears the set, possibly further loads, then one to nine requests.
    task automatic add_run(int tgt);
        int n;
        int lo;
        int hi;
        int pick;
        pick = $urandom_range(0, 9);
        n    = (pick == 0) ? $urandom_range(12, 18) : $urandom_range(1, 7);
        if (tgt >= 8000) begin
            lo = 900;
            hi = 1023;
        end else if (pick == 1) begin
            lo = 1;
            hi = 2;
        end else if (pick == 2) begin
            lo = 0;
            hi = 1023;
        end else begin
            lo = 1;
            hi = (tgt > 12) ? tgt / 2 + 1 : 12;
        end
        for (int i = 0; i < n; i++)
            add_item(ssce_pkg::KIND_LOAD, 10'($urandom_range(lo, hi)), i == 0);
        repeat ($urandom_range(1, 9))
            add_item(ssce_pkg::KIND_NEXT, 10'($urandom()), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int targets[7];
        int made;
        targets = '{0, 16383, 12, 30, 16000, 60, 7};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_target(14'd10);
        add_item(ssce_pkg::KIND_NEXT, 10'd0, 1'b0);
        add_item(ssce_pkg::KIND_LOAD, 10'd0, 1'b1);
        add_item(ssce_pkg::KIND_NEXT, 10'd1023, 1'b1);
        add_item(ssce_pkg::KIND_LOAD, 10'd3, 1'b1);
        add_item(ssce_pkg::KIND_LOAD, 10'd3, 1'b0);
        add_item(ssce_pkg::KIND_LOAD, 10'd7, 1'b0);
        add_item(ssce_pkg::KIND_LOAD, 10'd10, 1'b0);
        add_item(ssce_pkg::KIND_LOAD, 10'd1023, 1'b0);
        add_item(ssce_pkg::KIND_LOAD, 10'd4, 1'b0);
        repeat (6) add_item(ssce_pkg::KIND_NEXT, 10'd0, 1'b1);
        add_item(ssce_pkg::KIND_LOAD, 10'd3, 1'b0);
        add_item(ssce_pkg::KIND_NEXT, 10'd682, 1'b0);
        add_item(ssce_pkg::KIND_NEXT, 10'd341, 1'b0);
        drain();

        for (int p = 0; p < 7; p++) begin
            if (p == 2) begin
                send_idle_pct = 77;
                recv_idle_pct = 24;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_target(targets[p] == 30 ? 14'($urandom_range(1, 200)) : 14'(targets[p]));
            made = 0;
            while (made < 45) begin
                if ($urandom_range(0, 9) == 0) begin
                    add_item(1'($urandom_range(0, 1)), 10'($urandom()),
                             1'($urandom_range(0, 1)));
                    made++;
                end else begin
                    add_run(target);
                    made = item_q.size();
                end
            end
            hold_req = (p == 3);
            drain();
            hold_req = 1'b0;
        end

        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ssce_pkg.sv
hw/rtl/ssce_ram.sv
hw/rtl/ssce_outreg.sv
hw/rtl/subset_sum_combination_enumerator_unit.sv
tb/tb_top.sv
